// File: design/dism_pkg.sv
// Package for the display idle/dim/sleep manager.
// Request codes, brightness limits and timing constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dism_pkg;

  localparam int unsigned LevelW = 7;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  // request codes
  localparam logic [ReqW-1:0] REQ_TICK    = 2'd0;
  localparam logic [ReqW-1:0] REQ_TOUCH   = 2'd1;
  localparam logic [ReqW-1:0] REQ_CONSUME = 2'd2;
  localparam logic [ReqW-1:0] REQ_NONE    = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_BRIGHT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DIM    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SLEEP  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_NONE   = 2'd3;

  localparam logic [LevelW-1:0] BRIGHT_MIN  = 7'd10;
  localparam logic [LevelW-1:0] BRIGHT_MAX  = 7'd100;
  localparam logic [LevelW-1:0] DIM_KNEE    = 7'd20;
  localparam logic [LevelW-1:0] DIM_FLOOR   = 7'd10;
  localparam logic [LevelW-1:0] LEVEL_OFF   = 7'd0;
  localparam logic [LevelW-1:0] DIM_MAX     = 7'd50;
  localparam logic [TimeW-1:0]  SLEEP_MARGIN = 32'd5000;

  localparam logic [LevelW-1:0] BRIGHT_RST = 7'd100;
  localparam logic [TimeW-1:0]  DIM_RST    = 32'd30000;
  localparam logic [TimeW-1:0]  SLEEP_RST  = 32'd60000;

  // one result beat
  typedef struct packed {
    logic [LevelW-1:0] display_level;
    logic              level_written;
    logic              is_dimmed;
    logic              is_sleeping;
    logic              wake_flag;
  } result_t;

  // max(sleep, dim + margin), margin sum saturated to 32 bits
  function automatic logic [TimeW-1:0] eff_sleep(input logic [TimeW-1:0] dim,
                                                 input logic [TimeW-1:0] slp);
    logic [TimeW:0]   sum;
    logic [TimeW-1:0] floor_val;
    sum       = {1'b0, dim} + {1'b0, SLEEP_MARGIN};
    floor_val = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
    return (slp < floor_val) ? floor_val : slp;
  endfunction

  function automatic logic [LevelW-1:0] sat_bright(input logic [LevelW-1:0] v);
    logic [LevelW-1:0] r;
    r = v;
    if (v < BRIGHT_MIN) r = BRIGHT_MIN;
    if (v > BRIGHT_MAX) r = BRIGHT_MAX;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/display_idle_dim_sleep_manager.sv
// Top level of the display idle/dim/sleep manager.
// Depends on dism_pkg (codes, limits, result struct, helper functions).
`timescale 1ns / 1ps
`default_nettype none
// Display inactivity manager. Each input beat is a tick (time plus button
// states), a touch, or a consume of the pending wake flag; each produces
// exactly one result beat with the shown level, a level-written strobe, the
// dimmed and asleep flags and, for a consume, the wake flag before clearing.
// Throughput is one beat per clock while results are taken: a beat lands in
// the input register, and once the result slot is free or draining, one
// subtract plus two compares against the timeouts decide the new state,
// which is written together with the result register. The effective sleep
// timeout, max(sleep, dim + 5000) saturated, is kept in its own register and
// refreshed on each timeout write, so the item path never sees that adder.
// Configuration is a plain write port (index 0 brightness, 1 dim timeout,
// 2 sleep timeout; index 3 ignored) and must only be used while idle.
module display_idle_dim_sleep_manager (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // configuration
  input  wire                               cfg_we_i,
  input  wire [dism_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire [dism_pkg::CfgDataW-1:0]      cfg_wdata_i,
  // request channel
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire [dism_pkg::ReqW-1:0]          req_type_i,
  input  wire [dism_pkg::TimeW-1:0]         now_ms_i,
  input  wire                               button_a_i,
  input  wire                               button_b_i,
  input  wire                               button_power_i,
  // result channel
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [dism_pkg::LevelW-1:0]       display_level_o,
  output logic                              level_written_o,
  output logic                              is_dimmed_o,
  output logic                              is_sleeping_o,
  output logic                              wake_flag_o
);
  import dism_pkg::*;

  // ---------------- configuration registers ----------------
  logic [LevelW-1:0] bright_q;
  logic [TimeW-1:0]  dim_q, sleep_q, eff_q;

  // ---------------- block state ----------------
  logic [TimeW-1:0]  last_q, last_d;
  logic              dimmed_q, dimmed_d;
  logic              asleep_q, asleep_d;
  logic              wake_q, wake_d;
  logic [LevelW-1:0] level_q, level_d;

  // ---------------- input register ----------------
  logic              in_valid_q;
  logic [ReqW-1:0]   req_q;
  logic [TimeW-1:0]  now_q;
  logic              any_btn_q;

  // ---------------- result register ----------------
  logic              out_valid_q;
  result_t           res_q, res_d;

  logic advance;
  // input stage moves on when the result slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q     <= req_type_i;
      now_q     <= now_ms_i;
      any_btn_q <= button_a_i | button_b_i | button_power_i;
    end
  end

  // ---------------- per-beat decision ----------------
  logic [TimeW-1:0]  idle;
  logic [LevelW-1:0] dim_lvl;
  logic              written, wake_out;
  logic              dim_hit, sleep_hit;

  assign idle      = now_q - last_q;        // wraps modulo 2^32
  assign dim_lvl   = (bright_q > DIM_KNEE) ? (bright_q >> 1) : DIM_FLOOR;
  assign dim_hit   = !dimmed_q && (idle > dim_q);
  assign sleep_hit = idle > eff_q;

  always_comb begin
    last_d   = last_q;
    dimmed_d = dimmed_q;
    asleep_d = asleep_q;
    wake_d   = wake_q;
    level_d  = level_q;
    written  = 1'b0;
    wake_out = 1'b0;
    unique case (req_q)
      REQ_TICK: begin
        if (asleep_q) begin
          if (any_btn_q) begin
            asleep_d = 1'b0;
            wake_d   = 1'b1;
            last_d   = now_q;
            dimmed_d = 1'b0;
            level_d  = bright_q;
            written  = 1'b1;
          end
        end else begin
          if (dim_hit) begin
            level_d  = dim_lvl;
            dimmed_d = 1'b1;
            written  = 1'b1;
          end
          // sleep overrides a same-beat dim
          if (sleep_hit) begin
            asleep_d = 1'b1;
            dimmed_d = 1'b0;
            level_d  = LEVEL_OFF;
            written  = 1'b1;
          end
        end
      end
      REQ_TOUCH: begin
        last_d = now_q;
        if (asleep_q) begin
          asleep_d = 1'b0;
          wake_d   = 1'b1;
          dimmed_d = 1'b0;
          level_d  = bright_q;
          written  = 1'b1;
        end else if (dimmed_q) begin
          dimmed_d = 1'b0;
          level_d  = bright_q;
          written  = 1'b1;
        end
      end
      REQ_CONSUME: begin
        wake_out = wake_q;
        wake_d   = 1'b0;
      end
      REQ_NONE: begin
        // reports state only
      end
      default: begin
      end
    endcase
    res_d.display_level = level_d;
    res_d.level_written = written;
    res_d.is_dimmed     = dimmed_d;
    res_d.is_sleeping   = asleep_d;
    res_d.wake_flag     = wake_out;
  end

  // ---------------- state and config update ----------------
  // The user must write config only while idle; the block does not enforce it (an advance wins).
  logic [LevelW-1:0] bright_new;
  assign bright_new = sat_bright(cfg_wdata_i[LevelW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= BRIGHT_RST;
      dim_q    <= DIM_RST;
      sleep_q  <= SLEEP_RST;
      eff_q    <= eff_sleep(DIM_RST, SLEEP_RST);
      last_q   <= '0;
      dimmed_q <= 1'b0;
      asleep_q <= 1'b0;
      wake_q   <= 1'b0;
      level_q  <= BRIGHT_RST;
    end else if (advance) begin
      last_q   <= last_d;
      dimmed_q <= dimmed_d;
      asleep_q <= asleep_d;
      wake_q   <= wake_d;
      level_q  <= level_d;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BRIGHT: begin
          bright_q <= bright_new;
          if (!dimmed_q) begin
            level_q <= bright_new;
          end
        end
        REG_DIM: begin
          dim_q <= cfg_wdata_i;
          eff_q <= eff_sleep(cfg_wdata_i, sleep_q);
        end
        REG_SLEEP: begin
          sleep_q <= cfg_wdata_i;
          eff_q   <= eff_sleep(dim_q, cfg_wdata_i);
        end
        REG_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign display_level_o = res_q.display_level;
  assign level_written_o = res_q.level_written;
  assign is_dimmed_o     = res_q.is_dimmed;
  assign is_sleeping_o   = res_q.is_sleeping;
  assign wake_flag_o     = res_q.wake_flag;

  // ---------------- assertions ----------------
  a_dim_sleep_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dimmed_q && asleep_q))
    else $error("dimmed and asleep at once");

  a_dim_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dimmed_q |-> (level_q <= DIM_MAX) && (level_q >= DIM_FLOOR))
    else $error("dimmed level out of range");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked result");

  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("processed beat produced no result");

endmodule
`default_nettype wire

// File: tb/tb_display_idle_dim_sleep_manager.sv
// Self-checking testbench for display_idle_dim_sleep_manager.
// Uses dism_pkg for codes and the result struct; needs only the design files.
// Directed stimulus table first, then randomized phases under varied settings.
`timescale 1ns / 1ps

module tb_display_idle_dim_sleep_manager;
  import dism_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned BEATS_PER_PHASE = 200;
  localparam int unsigned PHASES = 8;
  localparam int unsigned MAX_REPORTS = 20;

  // DUT-facing signals
  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ReqW-1:0]     req_type_i;
  logic [TimeW-1:0]    now_ms_i;
  logic                button_a_i;
  logic                button_b_i;
  logic                button_power_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [LevelW-1:0]   display_level_o;
  logic                level_written_o;
  logic                is_dimmed_o;
  logic                is_sleeping_o;
  logic                wake_flag_o;

  display_idle_dim_sleep_manager uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .now_ms_i       (now_ms_i),
    .button_a_i     (button_a_i),
    .button_b_i     (button_b_i),
    .button_power_i (button_power_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .display_level_o(display_level_o),
    .level_written_o(level_written_o),
    .is_dimmed_o    (is_dimmed_o),
    .is_sleeping_o  (is_sleeping_o),
    .wake_flag_o    (wake_flag_o)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: register copies plus the manager's own state.
  // ---------------------------------------------------------------------------
  logic [LevelW-1:0] cfg_bright;
  logic [TimeW-1:0]  cfg_dim_ms;
  logic [TimeW-1:0]  cfg_sleep_ms;
  logic [TimeW-1:0]  last_touch_ms;
  logic              dimmed;
  logic              asleep;
  logic              wake_held;
  logic [LevelW-1:0] shown;

  // status beats still owed by the DUT, oldest first
  result_t status_due[$];

  int unsigned errors;
  int unsigned beats_sent;
  int unsigned settings_used;
  int unsigned dims_seen;
  int unsigned sleeps_seen;
  int unsigned wakes_seen;
  int unsigned stall_cycles;
  bit          gaps_on;

  // Sleep threshold: the larger of the sleep timeout and dim timeout + margin,
  // where the margin sum clamps at all ones instead of wrapping.
  function automatic logic [TimeW-1:0] sleep_limit();
    logic [TimeW:0] floor_ms;
    floor_ms = {1'b0, cfg_dim_ms} + {1'b0, SLEEP_MARGIN};
    if (floor_ms[TimeW]) floor_ms = {1'b0, {TimeW{1'b1}}};
    return (cfg_sleep_ms < floor_ms[TimeW-1:0]) ? floor_ms[TimeW-1:0] : cfg_sleep_ms;
  endfunction

  function automatic void apply_setting(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    logic [LevelW-1:0] b;
    b = data[LevelW-1:0];
    case (idx)
      REG_BRIGHT: begin
        if (b < BRIGHT_MIN) b = BRIGHT_MIN;
        else if (b > BRIGHT_MAX) b = BRIGHT_MAX;
        cfg_bright = b;
        // also lands on the panel when not dimmed, asleep included
        if (!dimmed) shown = b;
      end
      REG_DIM:   cfg_dim_ms = data;
      REG_SLEEP: cfg_sleep_ms = data;
      default: ;
    endcase
  endfunction

  // Advances the manager by one request and returns the status it reports.
  function automatic result_t advance_display(logic [ReqW-1:0] req, logic [TimeW-1:0] now,
                                              logic [2:0] btn);
    result_t          r;
    logic [TimeW-1:0] idle;
    r = '0;
    idle = now - last_touch_ms;
    case (req)
      REQ_TICK: begin
        if (asleep) begin
          if (|btn) begin
            asleep = 1'b0;
            wake_held = 1'b1;
            last_touch_ms = now;
            dimmed = 1'b0;
            shown = cfg_bright;
            r.level_written = 1'b1;
          end
        end else begin
          if (!dimmed && idle > cfg_dim_ms) begin
            shown = (cfg_bright > DIM_KNEE) ? cfg_bright >> 1 : DIM_FLOOR;
            dimmed = 1'b1;
            r.level_written = 1'b1;
          end
          // may follow the dim in the same tick
          if (idle > sleep_limit()) begin
            asleep = 1'b1;
            dimmed = 1'b0;
            shown = LEVEL_OFF;
            r.level_written = 1'b1;
          end
        end
      end
      REQ_TOUCH: begin
        last_touch_ms = now;
        if (asleep || dimmed) begin
          if (asleep) wake_held = 1'b1;
          asleep = 1'b0;
          dimmed = 1'b0;
          shown = cfg_bright;
          r.level_written = 1'b1;
        end
      end
      REQ_CONSUME: begin
        r.wake_flag = wake_held;
        wake_held = 1'b0;
      end
      default: ;  // unused code: status only
    endcase
    r.display_level = shown;
    r.is_dimmed = dimmed;
    r.is_sleeping = asleep;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed stimulus table. Write rows carry a register index and data; beat
  // rows carry a request, a time and buttons {a, b, power}.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                  is_write;
    logic [1:0]          code;
    logic [TimeW-1:0]    val;
    logic [2:0]          btn;
    bit                  typed;
    result_t             want;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic void plan_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    plan_row_t row;
    row = '{1'b1, idx, data, 3'b000, 1'b0, '0};
    plan.push_back(row);
  endfunction

  function automatic void plan_beat(logic [ReqW-1:0] req, logic [TimeW-1:0] now,
                                    logic [2:0] btn);
    plan_row_t row;
    row = '{1'b0, req, now, btn, 1'b0, '0};
    plan.push_back(row);
  endfunction

  // beat with its status typed in: level, written, dimmed, asleep, wake
  function automatic void plan_check(logic [ReqW-1:0] req, logic [TimeW-1:0] now,
                                     logic [2:0] btn, logic [LevelW-1:0] lvl,
                                     logic wr, logic dm, logic sl, logic wk);
    plan_row_t row;
    row = '{1'b0, req, now, btn, 1'b1, '0};
    row.want = '{lvl, wr, dm, sl, wk};
    plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Inputs move on the falling edge only.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [ReqW-1:0] req, input logic [TimeW-1:0] now,
                           input logic [2:0] btn, input bit typed, input result_t want);
    result_t guess;
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= req;
    now_ms_i       <= now;
    button_a_i     <= btn[2];
    button_b_i     <= btn[1];
    button_power_i <= btn[0];
    do @(posedge clk_i); while (!in_ready_o);
    guess = advance_display(req, now, btn);
    status_due.push_back(typed ? want : guess);
    beats_sent++;
    if (guess.level_written && guess.is_sleeping) sleeps_seen++;
    else if (guess.level_written && guess.is_dimmed) dims_seen++;
    if (guess.wake_flag) wakes_seen++;
  endtask

  // Register writes happen only with the pipe empty and no beat offered.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    apply_setting(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Result side back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= gaps_on ? ($urandom_range(0, 99) >= 21) : 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted status beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: unexpected status beat, expected none, actual level %0d",
                   $time, display_level_o);
      end else begin
        want = status_due.pop_front();
        check_field("display_level", 32'(want.display_level), 32'(display_level_o));
        check_field("level_written", 32'(want.level_written), 32'(level_written_o));
        check_field("is_dimmed", 32'(want.is_dimmed), 32'(is_dimmed_o));
        check_field("is_sleeping", 32'(want.is_sleeping), 32'(is_sleeping_o));
        check_field("wake_flag", 32'(want.wake_flag), 32'(wake_flag_o));
      end
    end
  end

  // Watchdog: too many cycles with no beat moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles, %0d status beats outstanding",
                 $time, WATCHDOG_LIMIT, status_due.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    logic [TimeW-1:0]    t_ms;
    logic [TimeW-1:0]    span;
    logic [TimeW-1:0]    now;
    logic [ReqW-1:0]     req;
    logic [2:0]          btn;
    logic [CfgDataW-1:0] br;
    logic [CfgDataW-1:0] dm;
    logic [CfgDataW-1:0] sl;
    int unsigned         roll;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_BRIGHT;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_TICK;
    now_ms_i       = '0;
    button_a_i     = 1'b0;
    button_b_i     = 1'b0;
    button_power_i = 1'b0;
    out_ready_i    = 1'b1;
    errors         = 0;
    beats_sent     = 0;
    settings_used  = 1;
    dims_seen      = 0;
    sleeps_seen    = 0;
    wakes_seen     = 0;
    stall_cycles   = 0;
    gaps_on        = 1'b1;
    t_ms           = '0;

    // predictor reset state
    cfg_bright    = BRIGHT_RST;
    cfg_dim_ms    = DIM_RST;
    cfg_sleep_ms  = SLEEP_RST;
    last_touch_ms = '0;
    dimmed        = 1'b0;
    asleep        = 1'b0;
    wake_held     = 1'b0;
    shown         = BRIGHT_RST;

    // -- directed table --------------------------------------------------
    // out of reset: nothing to do, nothing pending, unused code is inert
    plan_check(REQ_TICK,    32'd0,          3'b000, 7'd100, 0, 0, 0, 0);
    plan_check(REQ_CONSUME, 32'd0,          3'b000, 7'd100, 0, 0, 0, 0);
    plan_check(REQ_NONE,    32'hFFFF_FFFF,  3'b111, 7'd100, 0, 0, 0, 0);
    // idle exactly at the dim timeout does not dim, one past it does
    plan_check(REQ_TICK,    32'd30000,      3'b000, 7'd100, 0, 0, 0, 0);
    plan_check(REQ_TICK,    32'd30001,      3'b000, 7'd50,  1, 1, 0, 0);
    plan_check(REQ_TOUCH,   32'd40000,      3'b000, 7'd100, 1, 0, 0, 0);
    // dim and sleep in one tick
    plan_check(REQ_TICK,    32'd105001,     3'b000, 7'd0,   1, 0, 1, 0);
    plan_check(REQ_TICK,    32'hFFFF_FFFF,  3'b000, 7'd0,   0, 0, 1, 0);
    // each button wakes on its own; wake flag read once then cleared
    plan_check(REQ_TICK,    32'd200,        3'b100, 7'd100, 1, 0, 0, 0);
    plan_check(REQ_CONSUME, 32'd201,        3'b000, 7'd100, 0, 0, 0, 1);
    plan_check(REQ_CONSUME, 32'd202,        3'b000, 7'd100, 0, 0, 0, 0);
    plan_check(REQ_TICK,    32'd199,        3'b000, 7'd0,   1, 0, 1, 0);  // idle wraps
    plan_check(REQ_TICK,    32'd300,        3'b010, 7'd100, 1, 0, 0, 0);
    plan_check(REQ_TICK,    32'd299,        3'b000, 7'd0,   1, 0, 1, 0);
    plan_check(REQ_TICK,    32'd5,          3'b001, 7'd100, 1, 0, 0, 0);
    // brightness saturation, low dim floor, write while dimmed
    plan_write(REG_BRIGHT, 32'd0);
    plan_check(REQ_TICK,    32'd30006,      3'b000, 7'd10,  1, 1, 0, 0);
    plan_write(REG_BRIGHT, 32'd127);
    plan_check(REQ_TICK,    32'd30007,      3'b000, 7'd10,  0, 1, 0, 0);
    plan_check(REQ_TOUCH,   32'd1000,       3'b000, 7'd100, 1, 0, 0, 0);
    plan_write(REG_BRIGHT, 32'd21);
    plan_beat(REQ_TICK,     32'd31001,      3'b000);
    plan_write(REG_BRIGHT, 32'd200);  // only the low 7 bits count
    plan_beat(REQ_TOUCH,    32'd2000,       3'b000);
    plan_beat(REQ_TICK,     32'd62001,      3'b000);
    // brightness write while asleep shows up, still asleep
    plan_write(REG_BRIGHT, 32'd55);
    plan_check(REQ_TICK,    32'd62002,      3'b000, 7'd55,  0, 0, 1, 0);
    // margin sum overflows: sleep threshold clamps at all ones
    plan_write(REG_DIM, 32'hFFFF_FFFF);
    plan_write(REG_SLEEP, 32'd0);
    plan_write(REG_NONE, 32'hFFFF_FFFF);  // ignored
    plan_beat(REQ_TOUCH,    32'd0,          3'b000);
    plan_write(REG_DIM, 32'd0);
    plan_beat(REQ_TICK,     32'd1,          3'b000);
    plan_beat(REQ_TICK,     32'd5001,       3'b000);
    plan_write(REG_SLEEP, 32'hFFFF_FFFF);
    plan_beat(REQ_TOUCH,    32'd10,         3'b111);
    plan_beat(REQ_TICK,     32'd9,          3'b000);
    plan_beat(REQ_CONSUME,  32'd11,         3'b000);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        write_reg(plan[i].code, plan[i].val);
        settings_used++;
      end else begin
        send_beat(plan[i].code, plan[i].val, plan[i].btn, plan[i].typed, plan[i].want);
      end
    end

    // -- random phases ---------------------------------------------------
    // Mostly a clock that runs forward with steps scaled to the timeouts, so
    // dim, sleep and wake all keep happening; some beats are pure noise.
    for (int ph = 0; ph < PHASES; ph++) begin
      gaps_on = (ph != 3);  // one phase runs at full rate both ways
      case (ph)
        1: begin br = 32'd10;  dm = 32'd0;          sl = 32'd0;          end
        2: begin br = 32'd100; dm = 32'd4294962295; sl = 32'hFFFF_FFFF;  end
        5: begin br = $urandom; dm = $urandom_range(0, 1500); sl = 32'd0; end
        default: begin
          br = $urandom;
          dm = $urandom_range(0, 3000);
          sl = $urandom_range(0, 9000);
        end
      endcase
      write_reg(REG_BRIGHT, br);
      write_reg(REG_DIM, dm);
      write_reg(REG_SLEEP, sl);
      write_reg(REG_NONE, $urandom);
      settings_used++;

      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          req = 2'($urandom_range(0, 3));
          now = $urandom;
          btn = 3'($urandom_range(0, 7));
        end else begin
          span = (roll < 60) ? (sleep_limit() >> 1) + 32'd16 : (cfg_dim_ms >> 2) + 32'd4;
          t_ms = t_ms + $urandom_range(0, span);
          now = t_ms;
          roll = $urandom_range(0, 99);
          req = (roll < 70) ? REQ_TICK : (roll < 85) ? REQ_TOUCH : REQ_CONSUME;
          btn = ($urandom_range(0, 99) < 20) ? 3'($urandom_range(1, 7)) : 3'b000;
        end
        send_beat(req, now, btn, 1'b0, '0);
      end
    end

    // -- drain -----------------------------------------------------------
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    errors += status_due.size();

    $display("Sent %0d request beats across %0d register settings.", beats_sent,
             settings_used);
    $display("Predicted %0d dims, %0d sleeps, %0d wake flags consumed; %0d errors.",
             dims_seen, sleeps_seen, wakes_seen, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: display_idle_dim_sleep_manager.f
design/dism_pkg.sv
design/display_idle_dim_sleep_manager.sv
tb/tb_display_idle_dim_sleep_manager.sv
